// File: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared payload types, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Bus command codes carried in the func field.
   localparam logic [2:0] FUNC_START    = 3'd0;
   localparam logic [2:0] FUNC_STOP     = 3'd1;
   localparam logic [2:0] FUNC_SEND     = 3'd2;
   localparam logic [2:0] FUNC_READ     = 3'd3;
   localparam logic [2:0] FUNC_WAIT_ACK = 3'd4;
   localparam logic [2:0] FUNC_ACK      = 3'd5;
   localparam logic [2:0] FUNC_NACK     = 3'd6;
   localparam logic [2:0] FUNC_NONE     = 3'd7;

   // Sub-phase code used for the trailing phase of a send.
   localparam logic [1:0] SUB_TAIL = 2'd3;

   localparam logic [15:0] BIT_DELAY_RESET = 16'd200;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic [7:0] rx_bits;
      logic       ack_level;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       sda_drive;
      logic [7:0] rx_byte;
      logic       ack_error;
      logic       last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_PHASE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic count_clr;
      logic count_inc;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic func_known;
      logic delay_done;
      logic out_free;
      logic phase_last;
   } dp_status_type;

endpackage

// File: design/i2cm_ctrl.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer controller
// Walks one command through its bus phases, pacing each phase by the delay
// counter and handing finished phases to the output register.
// ----------------------------------------------------------------------------
module i2cm_ctrl
   import i2cm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // An unknown command is taken and dropped without any phase.
            if (req_valid && status.func_known) begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (status.delay_done && status.out_free && status.phase_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
            cmd.count_clr = 1'b1;
         end
         ST_PHASE: begin
            cmd.emit = status.delay_done && status.out_free;
            cmd.count_clr = cmd.emit;
            cmd.count_inc = !status.delay_done;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: design/i2cm_datapath.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer datapath
// Holds the command, phase counters, line state, delay counter, the phase
// delay register and the result register.
// ----------------------------------------------------------------------------
module i2cm_datapath
   import i2cm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [15:0]   csr_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status
);

   req_type     cmd_ff;
   logic [2:0]  bit_idx_ff;
   logic [1:0]  sub_ff;
   logic [15:0] count_ff;
   logic [15:0] bit_delay_ff;
   logic        sda_ff;
   logic        drv_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     phase;
   logic        tx_bit;
   logic [16:0] count_next;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_delay_ff <= BIT_DELAY_RESET;
      end else if (csr_valid) begin
         bit_delay_ff <= csr_data;
      end
   end

   // Phase delay counter; a delay of zero behaves like a delay of one.
   assign count_next = {1'b0, count_ff} + 17'd1;

   always_ff @(posedge clock) begin
      if (cmd.count_clr) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_next[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_data;
      end
   end

   // Position inside the command: bit index and sub-phase within the bit.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bit_idx_ff <= '0;
         sub_ff <= '0;
      end else if (cmd.emit) begin
         if (cmd_ff.func == FUNC_SEND && sub_ff == 2'd2) begin
            if (bit_idx_ff == 3'd7) begin
               sub_ff <= SUB_TAIL;
            end else begin
               sub_ff <= '0;
               bit_idx_ff <= bit_idx_ff + 3'd1;
            end
         end else if (cmd_ff.func == FUNC_READ && sub_ff == 2'd2) begin
            sub_ff <= '0;
            bit_idx_ff <= bit_idx_ff + 3'd1;
         end else begin
            sub_ff <= sub_ff + 2'd1;
         end
      end
   end

   assign tx_bit = cmd_ff.tx_byte[~bit_idx_ff];

   always_comb begin
      phase = '0;
      phase.scl = 1'b1;
      phase.sda = 1'b1;
      phase.sda_drive = 1'b1;
      unique case (cmd_ff.func)
         FUNC_START: begin
            phase.scl = (sub_ff != 2'd2);
            phase.sda = (sub_ff == 2'd0);
            phase.last = (sub_ff == 2'd2);
         end
         FUNC_STOP: begin
            phase.scl = (sub_ff != 2'd0);
            phase.sda = (sub_ff == 2'd2);
            phase.last = (sub_ff == 2'd2);
         end
         FUNC_SEND: begin
            if (sub_ff == SUB_TAIL) begin
               phase.scl = 1'b0;
               phase.sda = cmd_ff.tx_byte[0];
               phase.last = 1'b1;
            end else if (sub_ff == 2'd0) begin
               // Hold the previous data level while SCL is low.
               phase.scl = 1'b0;
               phase.sda = drv_ff ? sda_ff : 1'b1;
            end else begin
               phase.scl = (sub_ff == 2'd2);
               phase.sda = tx_bit;
            end
         end
         FUNC_READ: begin
            phase.sda_drive = 1'b0;
            phase.scl = (sub_ff != 2'd2);
            phase.rx_byte = cmd_ff.rx_bits >> (~bit_idx_ff);
            phase.last = (bit_idx_ff == 3'd7) && (sub_ff == 2'd2);
         end
         FUNC_WAIT_ACK: begin
            if (cmd_ff.ack_level) begin
               // No acknowledge: finish with a stop and flag the error.
               phase.scl = (sub_ff != 2'd0);
               phase.sda = (sub_ff == 2'd2);
               phase.ack_error = 1'b1;
               phase.last = (sub_ff == 2'd2);
            end else begin
               phase.sda_drive = 1'b0;
               phase.scl = (sub_ff == 2'd0);
               phase.last = (sub_ff == 2'd1);
            end
         end
         FUNC_ACK, FUNC_NACK: begin
            phase.scl = (sub_ff == 2'd1);
            phase.sda = (cmd_ff.func == FUNC_NACK);
            phase.last = (sub_ff == 2'd2);
         end
         default: begin
            phase.last = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sda_ff <= 1'b1;
         drv_ff <= 1'b1;
      end else if (cmd.emit) begin
         sda_ff <= phase.sda;
         drv_ff <= phase.sda_drive;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= phase;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      status.func_known = (req_data.func != FUNC_NONE);
      status.delay_done = (count_next >= {1'b0, bit_delay_ff});
      status.out_free = !rsp_valid_ff || !rsp_stall;
      status.phase_last = phase.last;
   end

endmodule

// File: design/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Turns bus commands into runs of SCL/SDA phases, one result per phase.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_type (one bus command)
//   rsp      out        rsp_valid/rsp_stall   rsp_type (one bus phase)
//   csr      in         csr_valid/csr_ready   16-bit phase length in clocks
//
// Each phase is paced by the delay counter against bit_delay and is then
// placed in the result register (up to 25 phases for a send). Commands are
// handled one at a time and req_stall is high until the last phase is in the
// result register. A stall on rsp holds the sequencer at the end of the
// current phase. Reset sets the held SDA level high and bit_delay to 200.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   i2cm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   i2cm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
